@@ rtl/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the rotary setpoint debounce block.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int unsigned SetpointW = 10;
    localparam int unsigned DigitW    = 4;
    localparam int unsigned DebW      = 8;
    localparam int unsigned HoldW     = 16;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [SetpointW-1:0] SetpointMax   = 10'd999;
    localparam logic [SetpointW-1:0] SetpointReset = 10'd200;
    localparam logic [DebW-1:0]      DebounceMax   = 8'hFF;
    localparam logic [DebW-1:0]      DebLimitReset = 8'd16;
    localparam logic [HoldW-1:0]     HoldLimitReset = 16'd45000;

    typedef enum logic {
        CFG_DEBOUNCE_LIMIT = 1'b0,
        CFG_HOLD_LIMIT     = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [SetpointW-1:0] setpoint_tenths;
        logic [DigitW-1:0]    tens_digit;
        logic [DigitW-1:0]    units_digit;
        logic [DigitW-1:0]    tenths_digit;
        logic                 changed;
        logic                 armed;
    } t_result;

endpackage

@@ rtl/rsd_digits.sv @@
// ----------------------------------------------------------------------------
// rsd_digits
// Splits a setpoint of 0..999 tenths into its three decimal digits using
// reciprocal multiplies by constants.
// ----------------------------------------------------------------------------
module rsd_digits (
    input  logic [rsd_pkg::SetpointW-1:0] i_value,
    output logic [rsd_pkg::DigitW-1:0]    o_tens,
    output logic [rsd_pkg::DigitW-1:0]    o_units,
    output logic [rsd_pkg::DigitW-1:0]    o_tenths
);

    logic [15:0] w_hund_prod;
    logic [9:0]  w_rem;
    logic [14:0] w_ten_prod;
    logic [6:0]  w_rem7;

    // x / 100 == (x * 41) >> 12 for x below 1000
    assign w_hund_prod = {6'd0, i_value} * 16'd41;
    assign o_tens      = w_hund_prod[15:12];
    assign w_rem       = i_value - (10'({6'd0, o_tens}) * 10'd100);
    assign w_rem7      = w_rem[6:0];

    // x / 10 == (x * 205) >> 11 for x below 100
    assign w_ten_prod  = {8'd0, w_rem7} * 15'd205;
    assign o_units     = w_ten_prod[14:11];
    assign o_tenths    = 4'(w_rem7 - (7'({3'd0, o_units}) * 7'd10));

endmodule

@@ rtl/rotary_setpoint_debounce.sv @@
// ----------------------------------------------------------------------------
// rotary_setpoint_debounce
// Quadrature encoder setpoint stepper with debounce and display hold.
// ----------------------------------------------------------------------------
// One input transaction per timer tick carries the edge strobe and both pin
// levels. Each one yields exactly one result transaction: the setpoint in
// tenths, its three digits, and the changed and armed flags after that tick.
// The tick update and digit split are one combinational pass into a result
// register, valid the cycle after acceptance unless a stalled result holds
// it; one transaction per cycle is sustained while the receiver takes them.
// A skid register behind the result register keeps o_ready high while one
// result waits; o_ready drops only when both hold a result, and rises again
// the cycle after the receiver takes one.
// Config writes (index 0 debounce limit, 1 hold limit) act at their clock
// edge; users must make them only while idle; the block does not enforce it.
// Synchronous reset clears the flags and counters, loads the setpoint with
// 20.0 degrees and the limits with 16 and 45000, and empties both result
// registers.
// ----------------------------------------------------------------------------
module rotary_setpoint_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [rsd_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_edge_req,
    input  logic                          i_pin_a,
    input  logic                          i_pin_b,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rsd_pkg::SetpointW-1:0] o_setpoint_tenths,
    output logic [rsd_pkg::DigitW-1:0]    o_tens_digit,
    output logic [rsd_pkg::DigitW-1:0]    o_units_digit,
    output logic [rsd_pkg::DigitW-1:0]    o_tenths_digit,
    output logic                          o_changed,
    output logic                          o_armed
);

    logic [rsd_pkg::DebW-1:0]      r_deb_limit;
    logic [rsd_pkg::HoldW-1:0]     r_hold_limit;

    logic                          r_armed, n_armed;
    logic                          r_change, n_change;
    logic [rsd_pkg::DebW-1:0]      r_deb_cnt, n_deb_cnt;
    logic [rsd_pkg::HoldW-1:0]     r_hold_cnt, n_hold_cnt;
    logic [rsd_pkg::SetpointW-1:0] r_setpoint, n_setpoint;

    rsd_pkg::t_result              r_out, n_out;
    rsd_pkg::t_result              r_skid, n_skid;
    logic                          r_out_valid, n_out_valid;
    logic                          r_skid_valid, n_skid_valid;

    rsd_pkg::t_result              w_result;
    logic                          w_in_acc;
    logic                          w_out_acc;

    assign o_ready   = !r_skid_valid;
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = r_out_valid && i_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_limit  <= rsd_pkg::DebLimitReset;
            r_hold_limit <= rsd_pkg::HoldLimitReset;
        end else if (i_cfg_we) begin
            case (rsd_pkg::t_cfg_index'(i_cfg_index))
                rsd_pkg::CFG_DEBOUNCE_LIMIT: begin
                    r_deb_limit <= i_cfg_data[rsd_pkg::DebW-1:0];
                end
                rsd_pkg::CFG_HOLD_LIMIT: begin
                    r_hold_limit <= i_cfg_data[rsd_pkg::HoldW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // tick update
    always_comb begin
        logic [rsd_pkg::DebW-1:0]  deb;
        logic [rsd_pkg::HoldW-1:0] hold;
        logic                      armed;
        logic                      change;
        logic [rsd_pkg::SetpointW-1:0] sp;

        deb    = (r_deb_cnt == rsd_pkg::DebounceMax) ? r_deb_cnt : r_deb_cnt + 1'b1;
        hold   = r_hold_cnt + 1'b1;
        armed  = r_armed;
        change = r_change;
        sp     = r_setpoint;

        if (i_edge_req && !armed) begin
            armed  = 1'b1;
            deb    = '0;
            hold   = '0;
            change = 1'b1;
        end

        if (armed && (deb > r_deb_limit) && !i_pin_a) begin
            if (i_pin_b) begin
                if (sp < rsd_pkg::SetpointMax) begin
                    sp = sp + 1'b1;
                end
            end else begin
                if (sp != '0) begin
                    sp = sp - 1'b1;
                end
            end
            armed = 1'b0;
        end

        if (hold > r_hold_limit) begin
            change = 1'b0;
            hold   = '0;
        end

        n_deb_cnt  = deb;
        n_hold_cnt = hold;
        n_armed    = armed;
        n_change   = change;
        n_setpoint = sp;
    end

    rsd_digits u_digits (
        .i_value  (n_setpoint),
        .o_tens   (w_result.tens_digit),
        .o_units  (w_result.units_digit),
        .o_tenths (w_result.tenths_digit)
    );

    assign w_result.setpoint_tenths = n_setpoint;
    assign w_result.changed         = n_change;
    assign w_result.armed           = n_armed;

    // result register and skid
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_acc) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = 1'b0;
            end
        end
        if (w_in_acc) begin
            if (!r_out_valid || w_out_acc) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_change     <= 1'b0;
            r_deb_cnt    <= '0;
            r_hold_cnt   <= '0;
            r_setpoint   <= rsd_pkg::SetpointReset;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_armed    <= n_armed;
                r_change   <= n_change;
                r_deb_cnt  <= n_deb_cnt;
                r_hold_cnt <= n_hold_cnt;
                r_setpoint <= n_setpoint;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid           = r_out_valid;
    assign o_setpoint_tenths = r_out.setpoint_tenths;
    assign o_tens_digit      = r_out.tens_digit;
    assign o_units_digit     = r_out.units_digit;
    assign o_tenths_digit    = r_out.tenths_digit;
    assign o_changed         = r_out.changed;
    assign o_armed           = r_out.armed;

endmodule

@@ rtl/rsd_checker.sv @@
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level assertions for rotary_setpoint_debounce, bound to the top level.
// ----------------------------------------------------------------------------
module rsd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [rsd_pkg::SetpointW-1:0] o_setpoint_tenths,
    input logic [rsd_pkg::DigitW-1:0]    o_tens_digit,
    input logic [rsd_pkg::DigitW-1:0]    o_units_digit,
    input logic [rsd_pkg::DigitW-1:0]    o_tenths_digit
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input stalls only with a result already waiting
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    // digits agree with the setpoint
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((32'(o_tens_digit) * 100 + 32'(o_units_digit) * 10
                      + 32'(o_tenths_digit)) == 32'(o_setpoint_tenths)))
        else $error("digits do not match setpoint");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_setpoint_tenths <= rsd_pkg::SetpointMax))
        else $error("setpoint out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_setpoint_tenths)))
        else $error("stalled result changed");

endmodule

bind rotary_setpoint_debounce rsd_checker u_rsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_setpoint_tenths (o_setpoint_tenths),
    .o_tens_digit      (o_tens_digit),
    .o_units_digit     (o_units_digit),
    .o_tenths_digit    (o_tenths_digit)
);
